// ----- rtl/mlev_pkg.sv -----
// constants, opcode type and saturation helper for the maglev plant emulator
// used by maglev_plant_euler_step; depends on nothing else
package mlev_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned WIDE_W = 64;
  localparam int unsigned PROD_W = 128;
  localparam int unsigned MULB_W = 40;
  localparam int unsigned VOLT_W = 23;
  localparam int unsigned SETP_W = 26;

  localparam logic signed [31:0] POS_INIT  = 32'sd55834575;
  localparam logic signed [31:0] CUR_INIT  = 32'sd35710957;
  localparam logic [31:0]        DT_INIT   = 32'd42949673;
  localparam logic [31:0]        XINF_RAW  = 32'd30064771;
  localparam logic [31:0]        XI_RAW    = 32'd6867653;
  localparam logic [31:0]        LINF_Q32  = 32'd3458307667;
  localparam logic [31:0]        R_Q24     = 32'd195957883;
  localparam logic signed [63:0] G_RAW     = 64'sd164416717;
  localparam logic [31:0]        KF_Q40    = 32'd1098824433;
  localparam logic [63:0]        BIG_CAP   = 64'h4000_0000_0000_0000;
  localparam logic [63:0]        INC_CAP   = 64'h0000_0100_0000_0000;
  localparam logic [63:0]        NO_CAP    = 64'hFFFF_FFFF_FFFF_FFFF;

  // micro-op sequence of one integration step
  typedef enum logic [3:0] {
    OP_P2  = 4'd0,
    OP_LQ  = 4'd1,
    OP_DEN = 4'd2,
    OP_I2  = 4'd3,
    OP_FRC = 4'd4,
    OP_XIV = 4'd5,
    OP_RP2 = 4'd6,
    OP_T1  = 4'd7,
    OP_T2  = 4'd8,
    OP_DD  = 4'd9,
    OP_DV  = 4'd10,
    OP_DI  = 4'd11
  } op_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (x < -64'sd2147483648) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/maglev_plant_euler_step.sv -----
// maglev plant emulator: one explicit euler step per item on a shared
// shift-add multiplier and restoring divider; uses mlev_pkg
//
// channel  dir  handshake          payload
// in       in   in_valid/in_stall  in_cmd, in_drive_voltage, in_target_position
// out      out  out_valid/out_stall ball state, position error, setpoint
// cfg      in   cfg_valid/cfg_ready cfg_step_time
//
// a step item runs twelve multiplies (one multiplier bit per cycle, until the
// remaining multiplier bits run out) and three 128-bit divisions, with a load
// and a store state around each multiply and the update and finish states to
// close; a reset command reloads the initial ball state and goes straight to
// the finish state.
// synchronous active-low reset loads the initial ball state and dt.
// in_stall is high while an item is in work; a waiting result does not block
// the next item, only the end of the following one.
module maglev_plant_euler_step
  import mlev_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_cmd,
  input  logic signed [VOLT_W-1:0] in_drive_voltage,
  input  logic [SETP_W-1:0]        in_target_position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [31:0]       out_ball_position,
  output logic signed [31:0]       out_ball_velocity,
  output logic signed [31:0]       out_coil_current,
  output logic signed [31:0]       out_position_error,
  output logic [SETP_W-1:0]        out_echoed_setpoint,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [31:0]              cfg_step_time
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_STORE = 7'b0010000,
    S_UPD   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [31:0]        dt_r;
  logic signed [31:0] pos_r, vel_r, cur_r;
  logic signed [VOLT_W-1:0] volt_r;
  logic [SETP_W-1:0]  setp_r;

  logic [31:0]        pu_r, q_r;
  logic [63:0]        p2_r, den_r, i2_r, frc_r, rp2_r;
  logic signed [63:0] xiv_r, t1_r, t2_r, dd_r, dv_r, di_r;

  logic [PROD_W-1:0]  prod_r, mcand_r, n_r;
  logic [MULB_W-1:0]  mplier_r;
  logic [63:0]        c_r, rem_r;
  logic [6:0]         cnt_r;

  logic               out_valid_r;
  logic signed [31:0] o_pos_r, o_vel_r, o_cur_r, o_err_r;
  logic [SETP_W-1:0]  o_setp_r;

  // derived signed terms
  logic signed [63:0] acc_s, num_s, idot_s;
  logic [63:0]        acc_mag, num_mag, idot_mag;
  logic [31:0]        cur_mag, vel_mag;
  logic [22:0]        volt_mag;
  logic signed [32:0] p_s;

  // operand decode
  logic [63:0]        op_a, op_c, op_cap;
  logic [MULB_W-1:0]  op_b;
  logic               op_div, op_neg;
  logic [5:0]         op_sh;

  logic [PROD_W-1:0]  raw;
  logic [63:0]        val;
  logic signed [63:0] sval;
  logic [64:0]        r_sh;
  logic               ge;

  assign acc_s    = G_RAW - $signed(frc_r);
  assign num_s    = xiv_r - $signed(rp2_r);
  assign idot_s   = t1_r + t2_r;
  assign acc_mag  = acc_s[63] ? 64'(-acc_s) : 64'(acc_s);
  assign num_mag  = num_s[63] ? 64'(-num_s) : 64'(num_s);
  assign idot_mag = idot_s[63] ? 64'(-idot_s) : 64'(idot_s);
  assign cur_mag  = cur_r[31] ? 32'(-cur_r) : 32'(cur_r);
  assign vel_mag  = vel_r[31] ? 32'(-vel_r) : 32'(vel_r);
  assign volt_mag = volt_r[VOLT_W-1] ? 23'(-volt_r) : 23'(volt_r);
  assign p_s      = 33'(pos_r) + $signed({1'b0, XINF_RAW});

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_c   = 64'd1;
    op_cap = NO_CAP;
    op_div = 1'b0;
    op_neg = 1'b0;
    op_sh  = 6'd0;
    unique case (op_r)
      OP_P2: begin
        op_a = 64'(pu_r); op_b = 40'(pu_r);
      end
      OP_LQ: begin
        op_a = 64'(pu_r); op_b = 40'(LINF_Q32); op_sh = 6'd32;
      end
      OP_DEN: begin
        op_a = 64'(pu_r); op_b = 40'(q_r);
      end
      OP_I2: begin
        op_a = 64'(cur_mag); op_b = 40'(cur_mag);
      end
      OP_FRC: begin
        op_a = i2_r; op_b = 40'(KF_Q40); op_div = 1'b1; op_c = p2_r; op_cap = BIG_CAP;
      end
      OP_XIV: begin
        op_a = 64'(vel_mag); op_b = 40'(XI_RAW); op_neg = vel_r[31];
      end
      OP_RP2: begin
        op_a = p2_r; op_b = 40'(R_Q24); op_sh = 6'd32; op_cap = BIG_CAP;
      end
      OP_T1: begin
        op_a = num_mag; op_b = {cur_mag, 8'd0}; op_div = 1'b1; op_c = den_r;
        op_cap = BIG_CAP; op_neg = cur_r[31] ^ num_s[63];
      end
      OP_T2: begin
        op_a = 64'({volt_mag, 8'd0}); op_b = 40'(pu_r); op_div = 1'b1;
        op_c = 64'(q_r); op_neg = volt_r[VOLT_W-1];
      end
      OP_DD: begin
        op_a = 64'(vel_mag); op_b = 40'(dt_r); op_sh = 6'd24; op_neg = vel_r[31];
      end
      OP_DV: begin
        op_a = acc_mag; op_b = 40'(dt_r); op_sh = 6'd32; op_cap = INC_CAP;
        op_neg = acc_s[63];
      end
      OP_DI: begin
        op_a = idot_mag; op_b = 40'(dt_r); op_sh = 6'd32; op_cap = INC_CAP;
        op_neg = idot_s[63];
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // quotient or shifted product, saturated at the op's cap
  assign raw  = op_div ? n_r : (prod_r >> op_sh);
  assign val  = ((|raw[127:64]) || (raw[63:0] > op_cap)) ? op_cap : raw[63:0];
  assign sval = op_neg ? -$signed(val) : $signed(val);

  assign r_sh = {rem_r, n_r[127]};
  assign ge   = r_sh >= {1'b0, c_r};

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = in_cmd ? S_FIN : S_LOAD;
      S_LOAD:  state_nxt = S_MUL;
      S_MUL:   if (mplier_r == '0) state_nxt = op_div ? S_DIV : S_STORE;
      S_DIV:   if (cnt_r == 7'd127) state_nxt = S_STORE;
      S_STORE: begin
        if (op_r == OP_DI) begin
          op_nxt    = OP_P2;
          state_nxt = S_UPD;
        end else begin
          op_nxt    = op_t'(op_r + 4'd1);
          state_nxt = S_LOAD;
        end
      end
      S_UPD:   state_nxt = S_FIN;
      S_FIN:   if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_P2;
      dt_r        <= DT_INIT;
      pos_r       <= POS_INIT;
      vel_r       <= '0;
      cur_r       <= CUR_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (cfg_valid && cfg_ready) dt_r <= cfg_step_time;
      if (state_r == S_IDLE && in_valid && in_cmd) begin
        pos_r <= POS_INIT;
        vel_r <= '0;
        cur_r <= CUR_INIT;
      end
      if (state_r == S_UPD) begin
        pos_r <= sat32(64'(pos_r) + dd_r);
        vel_r <= sat32(64'(vel_r) + dv_r);
        cur_r <= sat32(64'(cur_r) + di_r);
      end
      if (state_r == S_FIN && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      volt_r <= in_drive_voltage;
      setp_r <= in_target_position;
      // clamp the gap at one unit so no divisor is zero
      pu_r   <= (p_s < 33'sd1) ? 32'd1 : p_s[31:0];
    end
    unique case (state_r)
      S_LOAD: begin
        prod_r   <= '0;
        mcand_r  <= PROD_W'(op_a);
        mplier_r <= op_b;
        c_r      <= op_c;
      end
      S_MUL: begin
        if (mplier_r != '0) begin
          if (mplier_r[0]) prod_r <= prod_r + mcand_r;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
        end else begin
          n_r   <= prod_r;
          rem_r <= '0;
          cnt_r <= '0;
        end
      end
      S_DIV: begin
        rem_r <= ge ? 64'(r_sh - {1'b0, c_r}) : r_sh[63:0];
        n_r   <= {n_r[126:0], ge};
        cnt_r <= cnt_r + 7'd1;
      end
      S_STORE: begin
        case (op_r)
          OP_P2:   p2_r  <= val;
          OP_LQ:   q_r   <= XI_RAW + val[31:0];
          OP_DEN:  den_r <= val;
          OP_I2:   i2_r  <= val;
          OP_FRC:  frc_r <= val;
          OP_XIV:  xiv_r <= sval;
          OP_RP2:  rp2_r <= val;
          OP_T1:   t1_r  <= sval;
          OP_T2:   t2_r  <= sval;
          OP_DD:   dd_r  <= sval;
          OP_DV:   dv_r  <= sval;
          OP_DI:   di_r  <= sval;
          default: di_r  <= sval;
        endcase
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          o_pos_r  <= pos_r;
          o_vel_r  <= vel_r;
          o_cur_r  <= cur_r;
          o_err_r  <= sat32(64'(pos_r) - 64'(setp_r));
          o_setp_r <= setp_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall            = (state_r != S_IDLE);
  assign cfg_ready           = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_ball_position   = o_pos_r;
  assign out_ball_velocity   = o_vel_r;
  assign out_coil_current    = o_cur_r;
  assign out_position_error  = o_err_r;
  assign out_echoed_setpoint = o_setp_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != S_IDLE)
    else $error("accepted item did not start work");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> c_r != '0)
    else $error("divide by zero");

  a_mul_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL && mplier_r == '0 |=> state_r == S_DIV || state_r == S_STORE)
    else $error("multiplier did not hand over");

  a_gap_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> pu_r != '0)
    else $error("zero gap reached the datapath");
`endif

endmodule

// ----- test/tb_maglev_plant_euler_step.sv -----
// testbench for maglev_plant_euler_step: a fixed-point euler step predictor,
// directed, dt sweep and random episodes with idle gaps; uses mlev_pkg
`timescale 1ns / 100ps

module tb_maglev_plant_euler_step;
  import mlev_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 64'd12_000_000;
  localparam logic [63:0] TWO32 = 64'h1_0000_0000;
  localparam logic [SETP_W-1:0] SETP_MAX = 26'd55834575;
  localparam logic signed [VOLT_W-1:0] VOLT_MAX = 23'sd3932160;
  localparam logic signed [VOLT_W-1:0] VOLT_MIN = -23'sd3932160;
  localparam int VOLT_HOLD = 1629300;  // roughly R*I at the rest current
  localparam bit CMD_STEP = 1'b0;
  localparam bit CMD_RESET = 1'b1;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] cur;
    logic signed [31:0] err;
    logic [SETP_W-1:0] setp;
  } plant_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = 1'b0;
  logic signed [VOLT_W-1:0] in_drive_voltage = '0;
  logic [SETP_W-1:0] in_target_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_ball_position;
  logic signed [31:0] out_ball_velocity;
  logic signed [31:0] out_coil_current;
  logic signed [31:0] out_position_error;
  logic [SETP_W-1:0] out_echoed_setpoint;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_step_time = '0;

  plant_out_t expected_states[$];
  int error_count = 0;
  longint unsigned cycle_count = 0;
  bit quiet_mode = 1'b0;

  // predictor copy of the plant
  logic signed [31:0] pl_pos, pl_vel, pl_cur;
  logic [31:0] pl_dt;

  maglev_plant_euler_step u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_drive_voltage(in_drive_voltage), .in_target_position(in_target_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ball_position(out_ball_position), .out_ball_velocity(out_ball_velocity),
    .out_coil_current(out_coil_current), .out_position_error(out_position_error),
    .out_echoed_setpoint(out_echoed_setpoint),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_step_time(cfg_step_time)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  // floor(a*b/c) on a 128-bit product, clipped at cap
  function automatic logic [63:0] mul_div_cap(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] c, input logic [63:0] cap);
    logic [127:0] q;
    q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
    return (q[127:64] != 0 || q[63:0] > cap) ? cap : q[63:0];
  endfunction

  function automatic logic signed [63:0] scale_by_dt(input logic signed [63:0] x,
                                                     input logic [63:0] dt);
    logic [63:0] q;
    q = mul_div_cap(abs64(x), dt, TWO32, INC_CAP);
    return x < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  task automatic plant_euler_step(input logic signed [VOLT_W-1:0] volt);
    logic signed [63:0] d, v, cur, p, force_t, acc, xiv, num, t1, t2, dd, dv, di;
    logic [63:0] pu, p2, q, den, i2, rp2, dt;
    d = pl_pos; v = pl_vel; cur = pl_cur; dt = {32'd0, pl_dt};
    p = d + $signed({32'd0, XINF_RAW});
    if (p < 1) p = 1;
    pu = p;
    p2 = pu * pu;
    q = {32'd0, XI_RAW} + ((pu * {32'd0, LINF_Q32}) >> 32);
    den = pu * q;
    i2 = abs64(cur) * abs64(cur);
    force_t = $signed(mul_div_cap(i2, {32'd0, KF_Q40}, p2, BIG_CAP));
    acc = G_RAW - force_t;
    xiv = v * $signed({32'd0, XI_RAW});
    rp2 = mul_div_cap(p2, {32'd0, R_Q24}, TWO32, BIG_CAP);
    num = xiv - $signed(rp2);
    t1 = $signed(mul_div_cap(abs64(cur) << 8, abs64(num), den, BIG_CAP));
    if ((cur < 0) != (num < 0)) t1 = -t1;
    t2 = $signed(((abs64(64'(volt)) * pu) << 8) / q);
    if (volt < 0) t2 = -t2;
    dd = $signed((abs64(v) * dt) >> 24);
    if (v < 0) dd = -dd;
    dv = scale_by_dt(acc, dt);
    di = scale_by_dt(t1 + t2, dt);
    pl_pos = clip32(d + dd);
    pl_vel = clip32(v + dv);
    pl_cur = clip32(cur + di);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, $signed(got),
             $signed(want), cycle_count);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SETP_W-1:0] rand_setp();
    return SETP_W'($urandom_range(0, SETP_MAX));
  endfunction

  // sends one item and records what the plant should answer
  task automatic send_item(input bit cmd, input logic signed [VOLT_W-1:0] volt,
                           input logic [SETP_W-1:0] setp);
    plant_out_t exp_item;
    int gap;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_drive_voltage <= volt;
    in_target_position <= setp;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_RESET) begin
      pl_pos = POS_INIT; pl_vel = '0; pl_cur = CUR_INIT;
    end else begin
      plant_euler_step(volt);
    end
    exp_item.pos = pl_pos;
    exp_item.vel = pl_vel;
    exp_item.cur = pl_cur;
    exp_item.err = clip32(64'(pl_pos) - $signed({38'd0, setp}));
    exp_item.setp = setp;
    expected_states.push_back(exp_item);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_step_time(input logic [31:0] dt);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_step_time <= dt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pl_dt = dt;
  endtask

  function automatic logic signed [VOLT_W-1:0] near_hold_voltage();
    return VOLT_W'(VOLT_HOLD + $signed($urandom_range(0, 400000)) - 200000);
  endfunction

  task automatic test_directed();
    quiet_mode = 1'b1;
    send_item(CMD_STEP, 23'sd0, 26'd0);
    send_item(CMD_STEP, VOLT_MAX, SETP_MAX);
    send_item(CMD_STEP, VOLT_MIN, 26'd0);
    send_item(CMD_STEP, 23'sh3FFFFF, 26'h3FFFFFF);
    send_item(CMD_STEP, 23'sh400000, 26'h2AAAAAA);
    send_item(CMD_RESET, VOLT_MAX, 26'd0);
    send_item(CMD_RESET, 23'sd0, SETP_MAX);
    send_item(CMD_STEP, VOLT_W'(VOLT_HOLD), SETP_MAX);
    send_item(CMD_STEP, VOLT_W'(VOLT_HOLD), 26'd12345678);
    // large dt drives the ball into the coil and saturates the state
    write_step_time(32'hFFFF_FFFF);
    repeat (4) send_item(CMD_STEP, VOLT_MIN, 26'd0);
    repeat (4) send_item(CMD_STEP, VOLT_MAX, SETP_MAX);
    send_item(CMD_RESET, VOLT_MIN, 26'd1);
    // zero step leaves the state where it is
    write_step_time(32'd0);
    repeat (2) send_item(CMD_STEP, VOLT_MAX, 26'd7);
    write_step_time(32'd1);
    send_item(CMD_STEP, VOLT_MAX, 26'd7);
    write_step_time(DT_INIT);
    send_item(CMD_RESET, 23'sd0, 26'd0);
    quiet_mode = 1'b0;
  endtask

  task automatic test_step_sizes();
    logic [31:0] sizes[6];
    sizes = '{32'd1, 32'd4294967, DT_INIT, 32'd429496730, 32'hFFFF_FFFF, 32'd0};
    foreach (sizes[k]) begin
      write_step_time(sizes[k]);
      send_item(CMD_RESET, 23'sd0, rand_setp());
      repeat (6) send_item(CMD_STEP, near_hold_voltage(), rand_setp());
      repeat (3) send_item(CMD_STEP, VOLT_W'($urandom), rand_setp());
    end
  endtask

  task automatic test_random_episodes();
    int sent, len, r;
    logic [31:0] dt;
    sent = 0;
    while (sent < 1650) begin
      r = $urandom_range(0, 9);
      if (r < 6) dt = $urandom_range(1000000, 90000000);
      else if (r < 8) dt = $urandom;
      else dt = $urandom_range(1, 5000);
      write_step_time(dt);
      quiet_mode = ($urandom_range(0, 5) == 0);
      send_item(CMD_RESET, VOLT_W'($urandom), rand_setp());
      len = $urandom_range(10, 60);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 70) send_item(CMD_STEP, near_hold_voltage(), rand_setp());
        else if (r < 95) send_item(CMD_STEP, VOLT_W'($urandom), rand_setp());
        else send_item(CMD_RESET, VOLT_W'($urandom), rand_setp());
      end
      sent += len + 1;
    end
    quiet_mode = 1'b0;
  endtask

  // result side stall, with calm stretches
  always @(posedge clk) begin
    if (quiet_mode || $urandom_range(0, 3) != 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 9) < 7);
    end
  end

  always @(posedge clk) begin
    plant_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_states.size() == 0) begin
        $display("unexpected item at cycle %0d", cycle_count);
        error_count++;
      end else begin
        want = expected_states.pop_front();
        if (out_ball_position !== want.pos)
          report_mismatch("ball_position", 64'(out_ball_position), 64'(want.pos));
        if (out_ball_velocity !== want.vel)
          report_mismatch("ball_velocity", 64'(out_ball_velocity), 64'(want.vel));
        if (out_coil_current !== want.cur)
          report_mismatch("coil_current", 64'(out_coil_current), 64'(want.cur));
        if (out_position_error !== want.err)
          report_mismatch("position_error", 64'(out_position_error), 64'(want.err));
        if (out_echoed_setpoint !== want.setp)
          report_mismatch("echoed_setpoint", 64'(out_echoed_setpoint), 64'(want.setp));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    pl_pos = POS_INIT; pl_vel = '0; pl_cur = CUR_INIT; pl_dt = DT_INIT;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_step_sizes();
    test_random_episodes();
    wait_idle();
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_states.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
